>>> sv/ole_pkg.sv
// Shared types and codes for the ordered list engine.
// Depends on nothing; every file but the two channel interfaces imports it.
package ole_pkg;

    // Action selector codes
    localparam logic [2:0] ACT_APPEND    = 3'd0;
    localparam logic [2:0] ACT_DEL_FIRST = 3'd1;
    localparam logic [2:0] ACT_DEL_LAST  = 3'd2;
    localparam logic [2:0] ACT_DEL_POS   = 3'd3;
    localparam logic [2:0] ACT_READ      = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Decoded class of the held item
    typedef enum logic [2:0] {
        OP_APPEND,
        OP_FULL,
        OP_TRUNC,
        OP_SHIFT,
        OP_READ,
        OP_REJECT
    } op_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       latch;       // capture the accepted item
        logic       append;      // write value at the tail, count up
        logic       trunc;       // count down
        logic       shift_load;  // load the shift index with the gap start
        logic       shift_rd;    // read the entry behind the index
        logic       shift_wr;    // write it at the index, advance
        logic       read_issue;  // read the entry at the position
        logic       read_take;   // capture the read data as result
        logic       set_status;  // record the result status
        logic [1:0] status_code;
        logic       out_load;    // move the result into the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        logic shift_more;  // another entry must move down
        logic out_free;    // output register can take a result
    } sts_t;

endpackage

>>> sv/ole_in_if.sv
// Input channel of the ordered list engine: valid, ready and one item.
// Depends on nothing.
interface ole_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic signed [31:0] value;
    logic [4:0]        position;

    modport source (output valid, output action, output value, output position,
                    input ready);
    modport sink (input valid, input action, input value, input position,
                  output ready);
endinterface

>>> sv/ole_out_if.sv
// Result channel of the ordered list engine: valid, ready and one result.
// Depends on nothing.
interface ole_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [4:0]         count;
    logic signed [31:0] read_value;

    modport source (output valid, output status, output count, output read_value,
                    input ready);
    modport sink (input valid, input status, input count, input read_value,
                  output ready);
endinterface

>>> sv/ole_ctrl.sv
// Sequencer of the ordered list engine: one-hot state machine issuing commands.
// Depends on ole_pkg.
module ole_ctrl
    import ole_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SH_CHK = 6'b000100,
        S_SH_WR  = 6'b001000,
        S_RD_WT  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.op)
                    OP_APPEND:
                    begin
                        cmd.append      = 1'b1;
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_DONE;
                        state_next      = S_FINISH;
                    end
                    OP_FULL:
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_FULL;
                        state_next      = S_FINISH;
                    end
                    OP_TRUNC:
                    begin
                        cmd.trunc       = 1'b1;
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_DONE;
                        state_next      = S_FINISH;
                    end
                    OP_SHIFT:
                    begin
                        cmd.shift_load = 1'b1;
                        state_next     = S_SH_CHK;
                    end
                    OP_READ:
                    begin
                        cmd.read_issue = 1'b1;
                        state_next     = S_RD_WT;
                    end
                    default:
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_RANGE;
                        state_next      = S_FINISH;
                    end
                endcase
            end
            S_SH_CHK:
            begin
                if (sts.shift_more)
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SH_WR;
                end
                else
                begin
                    cmd.trunc       = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_DONE;
                    state_next      = S_FINISH;
                end
            end
            S_SH_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SH_CHK;
            end
            S_RD_WT:
            begin
                cmd.read_take   = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_DONE;
                state_next      = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> sv/ole_dpath.sv
// Datapath of the ordered list engine: element memory, count, shift index,
// held item and output register. Depends on ole_pkg.
module ole_dpath
    import ole_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         action,
    input  logic signed [31:0] value,
    input  logic [4:0]         position,
    input  cmd_t               cmd,
    output sts_t               sts,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_status,
    output logic [4:0]         out_count,
    output logic signed [31:0] out_read_value
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [2:0]            act_reg;
    logic [31:0]           val_reg;
    logic [4:0]            pos_reg;
    logic [CW-1:0]         cnt_reg;
    logic [AW-1:0]         idx_reg;
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [1:0]            res_status_reg;
    logic [DATA_WIDTH-1:0] res_value_reg;
    logic                  out_valid_reg;
    logic [1:0]            out_status_reg;
    logic [4:0]            out_count_reg;
    logic [31:0]           out_value_reg;

    logic                  pos_ok;
    logic                  is_full;
    logic [AW-1:0]         pos_idx;
    logic [AW-1:0]         shift_start;
    logic [CW-1:0]         idx_plus;
    logic [63:0]           value_wide;
    logic [63:0]           res_wide;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    op_t                   op_dec;

    // Decode the held item against the count
    assign pos_ok      = (pos_reg != 5'd0) && (CMPW'(pos_reg) <= CMPW'(cnt_reg));
    assign is_full     = (CMPW'(cnt_reg) >= CMPW'(DEPTH));
    assign pos_idx     = AW'(pos_reg - 5'd1);
    assign shift_start = (act_reg == ACT_DEL_FIRST) ? '0 : pos_idx;
    assign idx_plus    = CW'(idx_reg) + CW'(1);

    always_comb
    begin
        unique case (act_reg)
            ACT_APPEND:    op_dec = is_full ? OP_FULL : OP_APPEND;
            ACT_DEL_FIRST: op_dec = (cnt_reg != '0) ? OP_SHIFT : OP_REJECT;
            ACT_DEL_LAST:  op_dec = (cnt_reg != '0) ? OP_TRUNC : OP_REJECT;
            ACT_DEL_POS:   op_dec = pos_ok ? OP_SHIFT : OP_REJECT;
            ACT_READ:      op_dec = pos_ok ? OP_READ : OP_REJECT;
            default:       op_dec = OP_REJECT;
        endcase
    end

    assign sts.op         = op_dec;
    assign sts.shift_more = (idx_plus < cnt_reg);
    assign sts.out_free   = !out_valid_reg || out_ready;

    // Memory port selection
    assign value_wide = 64'(val_reg);
    assign wr_en      = cmd.append || cmd.shift_wr;
    assign wr_addr    = cmd.append ? AW'(cnt_reg) : idx_reg;
    assign wdata      = cmd.append ? value_wide[DATA_WIDTH-1:0] : rdata_reg;
    assign rd_en      = cmd.shift_rd || cmd.read_issue;
    assign rd_addr    = cmd.read_issue ? pos_idx : AW'(idx_plus);

    // Element memory with registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= wdata;
    end

    // Hold the item, shift index and result
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg <= action;
            val_reg <= value;
            pos_reg <= position;
        end
        if (cmd.shift_load)
            idx_reg <= shift_start;
        else if (cmd.shift_wr)
            idx_reg <= AW'(idx_plus);
        if (cmd.latch)
            res_value_reg <= '0;
        else if (cmd.read_take)
            res_value_reg <= rdata_reg;
        if (cmd.set_status)
            res_status_reg <= cmd.status_code;
    end

    // Track the element count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.append)
            cnt_reg <= cnt_reg + CW'(1);
        else if (cmd.trunc)
            cnt_reg <= cnt_reg - CW'(1);
    end

    // Output register
    assign res_wide = 64'(res_value_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_count_reg  <= 5'(cnt_reg);
            out_value_reg  <= res_wide[31:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_count      = out_count_reg;
    assign out_read_value = out_value_reg;

endmodule

>>> sv/ordered_list_engine.sv
// Ordered list engine: bounded ordered list of words held in a memory, one item at a time.
// Each accepted item is decoded, then a finish state loads its result into the output
// register; a read first waits on the registered memory read, and a delete at position p
// (p = 1 for delete first) moves each later entry down; the next item waits for the load.
// A result still waiting in the output register holds the next result back until taken.
// Reset clears the count, the sequencer and the output valid.
module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    ole_in_if.sink     req,
    ole_out_if.source  rsp
);

    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    assign req.ready = in_ready;

    // Sequencer
    ole_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // List storage and result path
    ole_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .action         (req.action),
        .value          (req.value),
        .position       (req.position),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_status     (rsp.status),
        .out_count      (rsp.count),
        .out_read_value (rsp.read_value)
    );

endmodule

>>> sim/ole_list_checker.sv
`timescale 1ns / 100ps
// Result checker for the ordered list engine: watches both channels and keeps its own list.
// Depends on ole_pkg and the ole_in_if / ole_out_if interfaces.
module ole_list_checker
    import ole_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ole_in_if    req_mon,
    ole_out_if   rsp_mon,
    output int   fail_count,
    output int   results_due
);

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         count;
        logic signed [31:0] read_value;
    } list_result_t;

    localparam int LIST_DEPTH   = 16;
    localparam int REPORT_LIMIT = 10;

    logic signed [31:0] list_cells [LIST_DEPTH];
    int                 list_len;
    list_result_t       expected_results [$];
    int                 mismatch_count;

    assign fail_count = mismatch_count;

    // Close the gap at idx and shorten the list by one
    task automatic close_gap(input int idx);
        for (int k = idx; k + 1 < list_len; k++)
        begin
            list_cells[k] = list_cells[k + 1];
        end
        list_len--;
    endtask

    // Apply one action to the local list and form the result it should produce
    task automatic apply_list_action(input logic [2:0] act, input logic signed [31:0] val,
                                     input logic [4:0] pos, output list_result_t res);
        logic [1:0]         st;
        logic signed [31:0] rd;
        st = ST_RANGE;
        rd = '0;
        case (act)
            ACT_APPEND:
            begin
                if (list_len >= LIST_DEPTH)
                    st = ST_FULL;
                else
                begin
                    list_cells[list_len] = val;
                    list_len++;
                    st = ST_DONE;
                end
            end
            ACT_DEL_FIRST:
            begin
                if (list_len > 0)
                begin
                    close_gap(0);
                    st = ST_DONE;
                end
            end
            ACT_DEL_LAST:
            begin
                if (list_len > 0)
                begin
                    list_len--;
                    st = ST_DONE;
                end
            end
            ACT_DEL_POS:
            begin
                if (pos >= 1 && int'(pos) <= list_len)
                begin
                    close_gap(int'(pos) - 1);
                    st = ST_DONE;
                end
            end
            ACT_READ:
            begin
                if (pos >= 1 && int'(pos) <= list_len)
                begin
                    rd = list_cells[int'(pos) - 1];
                    st = ST_DONE;
                end
            end
            default:
            begin
                // unused codes change nothing
            end
        endcase
        res.status     = st;
        res.count      = 5'(list_len);
        res.read_value = rd;
    endtask

    // Predict on every accepted item, compare every accepted result
    always @(posedge clk)
    begin
        list_result_t due;
        list_result_t seen;
        if (!rst_n)
        begin
            list_len = 0;
            mismatch_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (req_mon.valid && req_mon.ready)
            begin
                apply_list_action(req_mon.action, req_mon.value, req_mon.position, due);
                expected_results.push_back(due);
            end
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                seen.status     = rsp_mon.status;
                seen.count      = rsp_mon.count;
                seen.read_value = rsp_mon.read_value;
                if (expected_results.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: result with none pending: status %0d count %0d value %0d",
                                 $time, seen.status, seen.count, seen.read_value);
                    mismatch_count++;
                end
                else
                begin
                    due = expected_results.pop_front();
                    if (seen.status !== due.status || seen.count !== due.count
                        || seen.read_value !== due.read_value)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                        begin
                            $write("%0t: result mismatch: expected status %0d count %0d ",
                                   $time, due.status, due.count);
                            $display("value %0d, got status %0d count %0d value %0d",
                                     due.read_value, seen.status, seen.count,
                                     seen.read_value);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
        results_due <= expected_results.size();
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the ordered list engine testbench: clock, reset, stimulus, receiver and verdict.
// Depends on ole_pkg, the channel interfaces, ordered_list_engine and ole_list_checker.
module tb_top
    import ole_pkg::*;
();

    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int         LONG_STALL   = 300;
    localparam int         TAIL_CYCLES  = 60;
    localparam int         RUN_LIMIT_NS = 4_000_000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int  src_idle_pct  = 0;
    int  sink_idle_pct = 0;
    bit  stall_ask     = 1'b0;
    int  fail_count;
    int  results_due;

    ole_in_if  req_ch ();
    ole_out_if rsp_ch ();

    ordered_list_engine #(
        .DEPTH      (16),
        .DATA_WIDTH (32)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ole_list_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_mon     (req_ch),
        .rsp_mon     (rsp_ch),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always #4 clk = ~clk;

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input logic [2:0] act, input logic signed [31:0] val,
                             input logic [4:0] pos);
        while ($urandom_range(99, 0) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.value    <= val;
        req_ch.position <= pos;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Stop offering and wait for every pending result
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    // Random list traffic: alternate growing and shrinking stretches
    task automatic send_random_items(input int n);
        logic [2:0]         act;
        logic signed [31:0] val;
        logic [4:0]         pos;
        bit                 grow;
        int                 r;
        for (int i = 0; i < n; i++)
        begin
            grow = ((i / 40) % 2) == 0;
            r = $urandom_range(99, 0);
            if (r < 3)
                act = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
            else if (r < (grow ? 58 : 18))
                act = ACT_APPEND;
            else if (r < (grow ? 78 : 40))
                act = ACT_READ;
            else if (r < (grow ? 88 : 70))
                act = ACT_DEL_POS;
            else if (r < (grow ? 94 : 85))
                act = ACT_DEL_FIRST;
            else
                act = ACT_DEL_LAST;
            r = $urandom_range(99, 0);
            if (r < 85)
                pos = 5'($urandom_range(16, 1));
            else if (r < 95)
                pos = '0;
            else
                pos = 5'($urandom_range(31, 17));
            r = $urandom_range(99, 0);
            case (r % 10)
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7FFF_FFFF;
                2:       val = -32'sd1;
                default: val = $urandom;
            endcase
            if (r >= 10)
                val = $urandom;
            send_item(act, val, pos);
        end
    endtask

    // Receiver: random ready, with a long hold-off on request
    initial
    begin
        int  stall_left;
        bit  stall_seen;
        stall_left = 0;
        stall_seen = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                rsp_ch.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (stall_ask != stall_seen)
            begin
                stall_seen = stall_ask;
                stall_left = LONG_STALL;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
        end
    end

    // Stimulus and verdict
    initial
    begin
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_APPEND;
        req_ch.value    = '0;
        req_ch.position = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        src_idle_pct  = 18;
        sink_idle_pct = 49;

        // Empty list: every delete and read is refused
        send_item(ACT_READ, 32'sd0, 5'd1);
        send_item(ACT_DEL_FIRST, 32'sd0, 5'd0);
        send_item(ACT_DEL_LAST, 32'sd0, 5'd0);
        send_item(ACT_DEL_POS, 32'sd0, 5'd1);
        send_item(ACT_SPARE_HI, 32'sd0, 5'd31);
        // Delete the only element
        send_item(ACT_APPEND, 32'sd123, 5'd0);
        send_item(ACT_DEL_POS, 32'sd0, 5'd1);
        // Fill to the top with the extreme words first
        for (int k = 0; k < 16; k++)
        begin
            case (k)
                0:       send_item(ACT_APPEND, 32'sh8000_0000, 5'd0);
                1:       send_item(ACT_APPEND, 32'sh7FFF_FFFF, 5'd0);
                2:       send_item(ACT_APPEND, -32'sd1, 5'd0);
                3:       send_item(ACT_APPEND, 32'sd0, 5'd0);
                default: send_item(ACT_APPEND, $urandom, 5'($urandom));
            endcase
        end
        // Full list, last and out-of-range positions
        send_item(ACT_APPEND, 32'sh5555_5555, 5'd0);
        send_item(ACT_READ, 32'sd0, 5'd16);
        send_item(ACT_READ, 32'sd0, 5'd0);
        send_item(ACT_DEL_POS, 32'sd0, 5'd17);

        send_random_items(120);
        stall_ask <= ~stall_ask;
        send_random_items(110);
        drain_results();

        src_idle_pct  = 49;
        sink_idle_pct = 18;
        send_random_items(250);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random_items(250);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> files.f
sv/ole_pkg.sv
sv/ole_in_if.sv
sv/ole_out_if.sv
sv/ole_ctrl.sv
sv/ole_dpath.sv
sv/ordered_list_engine.sv
sim/ole_list_checker.sv
sim/tb_top.sv
